/* rtl/core/library_record_header_decode_core_defines.svh */
// assertion macros for the record header decoder checker
// no dependencies; expects clk and rst in the scope of use
`ifndef LIBRARY_RECORD_HEADER_DECODE_CORE_DEFINES_SVH
`define LIBRARY_RECORD_HEADER_DECODE_CORE_DEFINES_SVH

// same-cycle implication
`define LRHD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lrhd_pkg.sv */
// shared types, constants and character class function for the record header decoder
// no dependencies
`default_nettype none

package lrhd_pkg;

  // header layout
  localparam logic [7:0] LEAD_BIAS  = 8'd10;
  localparam logic [3:0] EXT_LEN    = 4'd3;
  localparam logic [4:0] WINDOW_LEN = 5'd16;
  localparam logic [31:0] MIN_RECORD = 32'd7;
  localparam logic [31:0] WIDE_MIN  = 32'h0000_8000;
  localparam logic [31:0] WIDE_MAX  = 32'h4000_0000;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  // size reading widths
  localparam logic [2:0] WIDTH_NONE = 3'd0;
  localparam logic [2:0] WIDTH_ONE  = 3'd1;
  localparam logic [2:0] WIDTH_TWO  = 3'd2;
  localparam logic [2:0] WIDTH_FOUR = 3'd4;

  // 16-byte window, byte 0 in bits 7:0
  typedef logic [15:0][7:0] window_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] base_chars;
    logic [1:0] ext_chars;
  } name_res_t;

  typedef struct packed {
    logic [1:0]  count;
    logic [2:0]  first_width;
    logic [30:0] first_size;
    logic [2:0]  second_width;
    logic [30:0] second_size;
  } size_res_t;

  typedef struct packed {
    logic        is_header;
    logic [1:0]  reading_count;
    logic [3:0]  name_field_length;
    logic [3:0]  base_chars;
    logic [1:0]  ext_chars;
    logic [2:0]  first_width;
    logic [30:0] first_size;
    logic [2:0]  second_width;
    logic [30:0] second_size;
  } result_t;

  // legal 8.3 name character
  function automatic logic legal_char(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 8'h41 && c <= 8'h5a) ok = 1'b1;
    if (c >= 8'h61 && c <= 8'h7a) ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2d, 8'h40, 8'h5e, 8'h5f, 8'h60, 8'h7b, 8'h7d, 8'h7e: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lrhd_in_if.sv */
// input channel: window word with valid/ready handshake
// no dependencies
`default_nettype none

interface lrhd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] window_low;
  logic [63:0] window_high;
  logic [4:0]  valid_bytes;
  logic [31:0] remaining;

  modport source (output valid, window_low, window_high, valid_bytes, remaining,
                  input ready);
  modport sink (input valid, window_low, window_high, valid_bytes, remaining,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/lrhd_out_if.sv */
// output channel: decode result word with valid/ready handshake
// no dependencies
`default_nettype none

interface lrhd_out_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [1:0]  reading_count;
  logic [3:0]  name_field_length;
  logic [3:0]  base_chars;
  logic [1:0]  ext_chars;
  logic [2:0]  first_width;
  logic [30:0] first_size;
  logic [2:0]  second_width;
  logic [30:0] second_size;

  modport source (output valid, is_header, reading_count, name_field_length, base_chars,
                  ext_chars, first_width, first_size, second_width, second_size,
                  input ready);
  modport sink (input valid, is_header, reading_count, name_field_length, base_chars,
                ext_chars, first_width, first_size, second_width, second_size,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/lrhd_name_check.sv */
// base name and extension field checker: legal characters, trailing-only blanks
// depends on lrhd_pkg
`default_nettype none

module lrhd_name_check
  import lrhd_pkg::*;
(
  input  window_t    win,
  input  logic [3:0] base,
  output name_res_t  res
);

  logic            seen_blank;
  logic            base_ok;
  logic [3:0]      bu;
  logic [2:0][7:0] ext_byte;
  logic            ext_blank;
  logic            ext_ok;
  logic [1:0]      eu;

  // base field, bytes 1..base
  always_comb begin
    seen_blank = 1'b0;
    base_ok    = 1'b1;
    bu         = '0;
    for (int i = 1; i <= 8; i++) begin
      if (4'(i) <= base) begin
        if (win[4'(i)] == CHAR_BLANK) begin
          seen_blank = 1'b1;
        end else begin
          if (seen_blank || !legal_char(win[4'(i)])) base_ok = 1'b0;
          bu = 4'(i);
        end
      end
    end
  end

  // extension bytes follow the base field
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext_byte[2'(k)] = win[4'(base + 4'(k + 1))];
    end
  end

  always_comb begin
    ext_blank = 1'b0;
    ext_ok    = 1'b1;
    eu        = '0;
    for (int k = 0; k < 3; k++) begin
      if (ext_byte[2'(k)] == CHAR_BLANK) begin
        ext_blank = 1'b1;
      end else begin
        if (ext_blank || !legal_char(ext_byte[2'(k)])) ext_ok = 1'b0;
        eu = 2'(k + 1);
      end
    end
  end

  assign res.ok         = base_ok && (bu != 4'd0) && ext_ok;
  assign res.base_chars = bu;
  assign res.ext_chars  = eu;

endmodule

`default_nettype wire

/* rtl/core/lrhd_size_read.sv */
// size field reader: one-byte or narrow reading plus wide reading, bounds checked
// depends on lrhd_pkg
`default_nettype none

module lrhd_size_read
  import lrhd_pkg::*;
(
  input  window_t     win,
  input  logic [3:0]  base,
  input  logic        one_byte,
  input  logic [4:0]  avail,
  input  logic [31:0] rem,
  output size_res_t   res
);

  logic [3:0]      sidx;
  logic [3:0][7:0] z;
  logic [15:0]     narrow_val;
  logic [31:0]     wide_val;
  logic [4:0]      start_a;
  logic [31:0]     size_a;
  logic            have_a;
  logic            fits_a;
  logic            ok_a;
  logic            have_w;
  logic            fits_w;
  logic            ok_w;

  // size field starts after lead, base and extension
  assign sidx = 4'(base + 4'd4);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      z[2'(k)] = win[4'(sidx + 4'(k))];
    end
  end

  assign narrow_val = {z[1], z[0]};
  assign wide_val   = {z[3], z[2], z[1], z[0]};

  // first reading: one byte or narrow two bytes
  assign start_a = one_byte ? 5'({1'b0, sidx} + 5'd1) : 5'({1'b0, sidx} + 5'd2);
  assign size_a  = one_byte ? {24'd0, z[0]} : {16'd0, narrow_val};
  assign have_a  = start_a <= avail;
  assign fits_a  = {1'b0, rem} >= (33'(start_a) + 33'(size_a));
  assign ok_a    = have_a && fits_a && (size_a != 32'd0) && (one_byte || !narrow_val[15]);

  // wide four-byte reading, only with a multi-byte size field
  assign have_w = 5'({1'b0, sidx} + 5'd4) <= avail;
  assign fits_w = {1'b0, rem} >= (33'({1'b0, sidx} + 5'd4) + 33'(wide_val));
  assign ok_w   = !one_byte && have_w && fits_w &&
                  (wide_val >= WIDE_MIN) && (wide_val <= WIDE_MAX);

  always_comb begin
    res.count        = 2'(ok_a) + 2'(ok_w);
    res.first_width  = WIDTH_NONE;
    res.first_size   = '0;
    res.second_width = WIDTH_NONE;
    res.second_size  = '0;
    if (ok_a) begin
      res.first_width = one_byte ? WIDTH_ONE : WIDTH_TWO;
      res.first_size  = size_a[30:0];
      if (ok_w) begin
        res.second_width = WIDTH_FOUR;
        res.second_size  = wide_val[30:0];
      end
    end else if (ok_w) begin
      res.first_width = WIDTH_FOUR;
      res.first_size  = wide_val[30:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/library_record_header_decode_core.sv */
// record header decoder: input register, single-pass decode, result register
// throughput: one word per cycle while the output is taken; the output register holds a stalled result
// while the input register keeps taking words until both are full
// reset: synchronous, active high, clears both valid flags; payload is not reset
// depends on lrhd_pkg, lrhd_in_if, lrhd_out_if, lrhd_name_check, lrhd_size_read
`default_nettype none

module library_record_header_decode_core
  import lrhd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  lrhd_in_if.sink     in_ch,
  lrhd_out_if.source  out_ch
);

  logic        s1_valid;
  logic [63:0] s1_window_low;
  logic [63:0] s1_window_high;
  logic [4:0]  s1_valid_bytes;
  logic [31:0] s1_remaining;
  logic        out_valid;
  result_t     res;
  result_t     res_next;
  logic        out_load;

  window_t     win;
  logic [4:0]  avail;
  logic [7:0]  lead;
  logic        lead_short;
  logic        lead_long;
  logic [3:0]  base;
  logic        span_ok;
  name_res_t   name_res;
  size_res_t   size_res;

  // handshake: output register frees when empty or taken
  assign out_load    = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || out_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_window_low  <= in_ch.window_low;
      s1_window_high <= in_ch.window_high;
      s1_valid_bytes <= in_ch.valid_bytes;
      s1_remaining   <= in_ch.remaining;
    end
  end

  // lead byte decode and span checks
  assign win        = {s1_window_high, s1_window_low};
  assign avail      = (s1_valid_bytes > WINDOW_LEN) ? WINDOW_LEN : s1_valid_bytes;
  assign lead       = win[0];
  assign lead_short = (lead >= LEAD_BIAS + 8'd1) && (lead <= LEAD_BIAS + 8'd8);
  assign lead_long  = (lead >= 8'd1) && (lead <= 8'd8);
  assign base       = lead_short ? 4'(lead - LEAD_BIAS) : lead[3:0];
  assign span_ok    = (s1_remaining >= MIN_RECORD) && (avail != 5'd0) &&
                      (lead_short || lead_long) &&
                      (5'({1'b0, base} + 5'd4) <= avail);

  lrhd_name_check u_name_check (
    .win  (win),
    .base (base),
    .res  (name_res)
  );

  lrhd_size_read u_size_read (
    .win      (win),
    .base     (base),
    .one_byte (lead_short),
    .avail    (avail),
    .rem      (s1_remaining),
    .res      (size_res)
  );

  // result word, all zero when not a header
  always_comb begin
    res_next = '0;
    if (span_ok && name_res.ok && (size_res.count != 2'd0)) begin
      res_next.is_header         = 1'b1;
      res_next.reading_count     = size_res.count;
      res_next.name_field_length = 4'(base + EXT_LEN);
      res_next.base_chars        = name_res.base_chars;
      res_next.ext_chars         = name_res.ext_chars;
      res_next.first_width       = size_res.first_width;
      res_next.first_size        = size_res.first_size;
      res_next.second_width      = size_res.second_width;
      res_next.second_size       = size_res.second_size;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
    if (out_load && s1_valid) begin
      res <= res_next;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.is_header         = res.is_header;
  assign out_ch.reading_count     = res.reading_count;
  assign out_ch.name_field_length = res.name_field_length;
  assign out_ch.base_chars        = res.base_chars;
  assign out_ch.ext_chars         = res.ext_chars;
  assign out_ch.first_width       = res.first_width;
  assign out_ch.first_size        = res.first_size;
  assign out_ch.second_width      = res.second_width;
  assign out_ch.second_size       = res.second_size;

endmodule

`default_nettype wire

/* rtl/core/lrhd_checker.sv */
// port-level checker for the record header decoder, bound to the top level
// depends on library_record_header_decode_core_defines.svh
`default_nettype none
`include "library_record_header_decode_core_defines.svh"

module lrhd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_header,
  input wire logic [1:0]  reading_count,
  input wire logic [3:0]  name_field_length,
  input wire logic [3:0]  base_chars,
  input wire logic [1:0]  ext_chars,
  input wire logic [2:0]  first_width,
  input wire logic [30:0] first_size,
  input wire logic [2:0]  second_width,
  input wire logic [30:0] second_size
);

  logic [80:0] stall_word;
  logic        reject_clear;
  logic        readings_ok;
  logic        names_ok;

  // whole offered word
  assign stall_word = {is_header, reading_count, name_field_length, base_chars, ext_chars,
                       first_width, first_size, second_width, second_size};

  // every field but is_header is zero
  assign reject_clear = reading_count == 2'd0 && name_field_length == 4'd0 &&
                        base_chars == 4'd0 && ext_chars == 2'd0 && first_width == 3'd0 &&
                        first_size == 31'd0 && second_width == 3'd0 && second_size == 31'd0;

  // reading count agrees with the reading widths
  assign readings_ok = (reading_count == 2'd1 && second_width == 3'd0 &&
                        second_size == 31'd0 &&
                        (first_width == 3'd1 || first_width == 3'd2 || first_width == 3'd4)) ||
                       (reading_count == 2'd2 && first_width == 3'd2 && second_width == 3'd4);

  // name lengths agree with each other
  assign names_ok = base_chars != 4'd0 && name_field_length >= base_chars + 4'd3;

  // stalled word stays offered
  `LRHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled word dropped")

  // stalled word keeps its fields
  `LRHD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(stall_word), "word changed")

  // a rejected window gives an all-zero word
  `LRHD_ASSERT_IMPL(a_reject_zero, out_valid && !is_header, reject_clear, "reject not zero")

  `LRHD_ASSERT_IMPL(a_readings, out_valid && is_header, readings_ok, "readings disagree")

  `LRHD_ASSERT_IMPL(a_names, out_valid && is_header, names_ok, "name lengths inconsistent")

endmodule

bind library_record_header_decode_core lrhd_checker u_lrhd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .is_header         (out_ch.is_header),
  .reading_count     (out_ch.reading_count),
  .name_field_length (out_ch.name_field_length),
  .base_chars        (out_ch.base_chars),
  .ext_chars         (out_ch.ext_chars),
  .first_width       (out_ch.first_width),
  .first_size        (out_ch.first_size),
  .second_width      (out_ch.second_width),
  .second_size       (out_ch.second_size)
);

`default_nettype wire
